>>> rtl/mfg_pkg.sv
// Package with the shared constants, codes and state type of the MAX-SAT flip engine.
package mfg_pkg;

    localparam int DEF_MAX_VARS    = 1024;
    localparam int DEF_MAX_CLAUSES = 4096;
    localparam int DEF_MAX_LITS    = 8;
    localparam int DEF_MAX_OCC     = 32;

    localparam int CMD_W     = 3;
    localparam int CLAUSE_W  = 12;
    localparam int VAR_W     = 11;
    localparam int WEIGHT_W  = 32;
    localparam int GAIN_W    = 49;
    localparam int TOTAL_W   = 48;
    localparam int ERR_W     = 2;
    localparam int NVARS_W   = 11;
    localparam int NCLS_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int CMP_W     = 18;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MAJ    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RECNT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLIP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_VARS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLAUSES = 2'd1;

    localparam logic [NVARS_W-1:0] NUM_VARS_RST = 11'd1024;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEC,
        ST_LD_RD,
        ST_LD_WR,
        ST_MJ_VAR,
        ST_MJ_CNT,
        ST_MJ_OCC,
        ST_MJ_CL,
        ST_MJ_ADD,
        ST_MJ_SET,
        ST_RC_CL,
        ST_RC_LEN,
        ST_RC_LIT,
        ST_RC_ASG,
        ST_RC_CHK,
        ST_RC_WR,
        ST_FL_RD,
        ST_FL_CNT,
        ST_FL_OCC,
        ST_FL_CL,
        ST_FL_HDR,
        ST_FL_LIT,
        ST_FL_CMP,
        ST_FL_EVAL,
        ST_FL_END,
        ST_TG_RD,
        ST_TG_WR,
        ST_FIN_RD,
        ST_FIN,
        ST_RESP
    } state_t;

endpackage

>>> rtl/mfg_if.sv
// Handshake interfaces for the command, result and configuration channels.
interface mfg_req_if;
    import mfg_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [CLAUSE_W-1:0] clause_index;
    logic [VAR_W-1:0]    var_index;
    logic                negated;
    logic [WEIGHT_W-1:0] clause_weight;
    modport source(output valid, command, clause_index, var_index, negated, clause_weight,
                   input ready);
    modport sink(input valid, command, clause_index, var_index, negated, clause_weight,
                 output ready);
endinterface

interface mfg_rsp_if;
    import mfg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [GAIN_W-1:0] gain;
    logic                     flipped;
    logic [TOTAL_W-1:0]       total_weight;
    logic                     var_value;
    logic [ERR_W-1:0]         error;
    modport source(output valid, gain, flipped, total_weight, var_value, error, input ready);
    modport sink(input valid, gain, flipped, total_weight, var_value, error, output ready);
endinterface

interface mfg_cfg_if;
    import mfg_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/maxsat_flip_gain_engine.sv
// Top level of the weighted MAX-SAT flip engine: clause store, sequencer and accumulator.
// Each command beat is taken only while the engine is idle and yields one result beat.
// A single 49-bit accumulator under a sequencer sums the clause weights, and every
// memory has a registered read, so time depends on the stored problem. Recount walks
// every clause in use and each of its literals. Try flip walks the variable's
// occurrences and scans each clause's literals up to the variable, skipping an
// occurrence of a clause out of range; when the gain is positive the flip is applied
// and the walk over the occurrences runs again. Majority start clears the value of
// each unused variable, sets each variable in use to true when the signed weight sum
// of its occurrences is positive, and then runs a recount. After reset a clearing
// pass over max(MAX_CLAUSES, MAX_VARS + 1) entries (4096 by default) zeroes the lengths,
// counts and assignment before the first command is accepted; configuration writes are
// taken at any time.
module maxsat_flip_gain_engine #(
    parameter int MAX_VARS    = mfg_pkg::DEF_MAX_VARS,
    parameter int MAX_CLAUSES = mfg_pkg::DEF_MAX_CLAUSES,
    parameter int MAX_LITS    = mfg_pkg::DEF_MAX_LITS,
    parameter int MAX_OCC     = mfg_pkg::DEF_MAX_OCC
) (
    input  logic      clk,
    input  logic      rst_n,
    mfg_req_if.sink   req,
    mfg_rsp_if.source rsp,
    mfg_cfg_if.sink   cfg
);
    import mfg_pkg::*;

    localparam int VW        = $clog2(MAX_VARS + 1);
    localparam int CW        = $clog2(MAX_CLAUSES);
    localparam int CW1       = $clog2(MAX_CLAUSES + 1);
    localparam int LW        = $clog2(MAX_LITS + 1);
    localparam int OCW       = $clog2(MAX_OCC + 1);
    localparam int LA_W      = $clog2(MAX_CLAUSES * MAX_LITS);
    localparam int OA_W      = $clog2((MAX_VARS + 1) * MAX_OCC);
    localparam int CLR_DEPTH = (MAX_CLAUSES > MAX_VARS + 1) ? MAX_CLAUSES : MAX_VARS + 1;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int TC_W      = 8;

    logic [VW:0]       lit_mem [MAX_CLAUSES*MAX_LITS];
    logic [CW:0]       occ_mem [(MAX_VARS+1)*MAX_OCC];
    logic [WEIGHT_W-1:0] wgt_mem [MAX_CLAUSES];
    logic [LW-1:0]     len_mem [MAX_CLAUSES];
    logic [TC_W-1:0]   tc_mem  [MAX_CLAUSES];
    logic [OCW-1:0]    ocnt_mem [MAX_VARS+1];
    logic              asg_mem [MAX_VARS+1];

    logic [VW:0]         rd_lit;
    logic [CW:0]         rd_occ;
    logic [WEIGHT_W-1:0] rd_wgt;
    logic [LW-1:0]       rd_len;
    logic [TC_W-1:0]     rd_tc;
    logic [OCW-1:0]      rd_ocnt;
    logic                rd_asg;

    logic [LA_W-1:0]     lit_ra, lit_wa;
    logic [VW:0]         lit_wd;
    logic                lit_we;
    logic [OA_W-1:0]     occ_ra, occ_wa;
    logic [CW:0]         occ_wd;
    logic                occ_we;
    logic [CW-1:0]       wgt_ra, wgt_wa;
    logic                wgt_we;
    logic [CW-1:0]       len_ra, len_wa;
    logic [LW-1:0]       len_wd;
    logic                len_we;
    logic [CW-1:0]       tc_ra, tc_wa;
    logic [TC_W-1:0]     tc_wd;
    logic                tc_we;
    logic [VW-1:0]       ocnt_ra, ocnt_wa;
    logic [OCW-1:0]      ocnt_wd;
    logic                ocnt_we;
    logic [VW-1:0]       asg_ra, asg_wa;
    logic                asg_wd;
    logic                asg_we;

    state_t state_reg, state_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic [NVARS_W-1:0]  num_vars_reg;
    logic [NCLS_W-1:0]   num_clauses_reg;

    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [CLAUSE_W-1:0] cl_reg, cl_next;
    logic [VAR_W-1:0]    var_reg, var_next;
    logic                neg_reg, neg_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;

    logic [VW-1:0]       vi_reg, vi_next;
    logic [CW1-1:0]      ci_reg, ci_next;
    logic [OCW-1:0]      oi_reg, oi_next;
    logic [OCW-1:0]      ocnt_reg, ocnt_next;
    logic [LW-1:0]       j_reg, j_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [TC_W-1:0]     cnt_reg, cnt_next;
    logic [TC_W-1:0]     tc_reg, tc_next;
    logic [WEIGHT_W-1:0] wc_reg, wc_next;
    logic [CW-1:0]       cc_reg, cc_next;
    logic                nc_reg, nc_next;
    logic                asgv_reg, asgv_next;
    logic                lt_reg, lt_next;
    logic                apply_reg, apply_next;
    logic                vok_reg, vok_next;
    logic signed [GAIN_W-1:0] acc_reg, acc_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [ERR_W-1:0]    err_reg, err_next;
    logic                flip_reg, flip_next;

    logic signed [GAIN_W-1:0] gain_o_reg, gain_o_next;
    logic                flip_o_reg, flip_o_next;
    logic [TOTAL_W-1:0]  total_o_reg, total_o_next;
    logic                val_o_reg, val_o_next;
    logic [ERR_W-1:0]    err_o_reg, err_o_next;

    logic [CMP_W-1:0] nv_eff, nc_eff;
    logic v_ok, load_ok, vi_ok, vi_last, ci_done, occ_ok, ld_full, acc_pos, clr_last;
    logic [CW-1:0]   occ_c;
    logic            occ_neg;
    logic [VW-1:0]   lit_var;
    logic            lit_neg;
    logic            lit_true_now;
    logic signed [GAIN_W-1:0] wc_ext, wgt_ext;

    assign nv_eff  = (CMP_W'(num_vars_reg) > CMP_W'(MAX_VARS)) ? CMP_W'(MAX_VARS)
                                                               : CMP_W'(num_vars_reg);
    assign nc_eff  = (CMP_W'(num_clauses_reg) > CMP_W'(MAX_CLAUSES)) ? CMP_W'(MAX_CLAUSES)
                                                                     : CMP_W'(num_clauses_reg);
    assign v_ok    = (var_reg != '0) && (CMP_W'(var_reg) <= nv_eff);
    assign load_ok = v_ok && (CMP_W'(cl_reg) < nc_eff);
    assign vi_ok   = (vi_reg != '0) && (CMP_W'(vi_reg) <= nv_eff);
    assign vi_last = (vi_reg == VW'(MAX_VARS));
    assign ci_done = (CMP_W'(ci_reg) >= nc_eff);
    assign occ_c   = rd_occ[CW-1:0];
    assign occ_neg = rd_occ[CW];
    assign occ_ok  = (CMP_W'(occ_c) < nc_eff);
    assign lit_var = rd_lit[VW-1:0];
    assign lit_neg = rd_lit[VW];
    assign ld_full = (rd_len >= LW'(MAX_LITS)) || (rd_ocnt >= OCW'(MAX_OCC));
    assign acc_pos = !acc_reg[GAIN_W-1] && (acc_reg != '0);
    assign clr_last = (clr_reg == CLR_W'(CLR_DEPTH - 1));
    assign lit_true_now = lit_neg ? !asgv_reg : asgv_reg;
    assign wc_ext  = $signed(GAIN_W'(wc_reg));
    assign wgt_ext = $signed(GAIN_W'(rd_wgt));

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = (state_reg == ST_RESP);
    assign rsp.gain           = gain_o_reg;
    assign rsp.flipped        = flip_o_reg;
    assign rsp.total_weight   = total_o_reg;
    assign rsp.var_value      = val_o_reg;
    assign rsp.error          = err_o_reg;
    assign cfg.ready          = 1'b1;

    always_ff @(posedge clk)
    begin
        if (lit_we)
        begin
            lit_mem[lit_wa] <= lit_wd;
        end
        rd_lit <= lit_mem[lit_ra];
    end

    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[occ_wa] <= occ_wd;
        end
        rd_occ <= occ_mem[occ_ra];
    end

    always_ff @(posedge clk)
    begin
        if (wgt_we)
        begin
            wgt_mem[wgt_wa] <= w_reg;
        end
        rd_wgt <= wgt_mem[wgt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_wa] <= len_wd;
        end
        rd_len <= len_mem[len_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tc_we)
        begin
            tc_mem[tc_wa] <= tc_wd;
        end
        rd_tc <= tc_mem[tc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ocnt_we)
        begin
            ocnt_mem[ocnt_wa] <= ocnt_wd;
        end
        rd_ocnt <= ocnt_mem[ocnt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (asg_we)
        begin
            asg_mem[asg_wa] <= asg_wd;
        end
        rd_asg <= asg_mem[asg_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            num_vars_reg    <= NUM_VARS_RST;
            num_clauses_reg <= '0;
            total_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            total_reg <= total_next;
            if (cfg.valid && cfg.index == REG_NUM_VARS)
            begin
                num_vars_reg <= cfg.data[NVARS_W-1:0];
            end
            if (cfg.valid && cfg.index == REG_NUM_CLAUSES)
            begin
                num_clauses_reg <= cfg.data[NCLS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cl_reg      <= cl_next;
        var_reg     <= var_next;
        neg_reg     <= neg_next;
        w_reg       <= w_next;
        vi_reg      <= vi_next;
        ci_reg      <= ci_next;
        oi_reg      <= oi_next;
        ocnt_reg    <= ocnt_next;
        j_reg       <= j_next;
        len_reg     <= len_next;
        cnt_reg     <= cnt_next;
        tc_reg      <= tc_next;
        wc_reg      <= wc_next;
        cc_reg      <= cc_next;
        nc_reg      <= nc_next;
        asgv_reg    <= asgv_next;
        lt_reg      <= lt_next;
        apply_reg   <= apply_next;
        vok_reg     <= vok_next;
        acc_reg     <= acc_next;
        err_reg     <= err_next;
        flip_reg    <= flip_next;
        gain_o_reg  <= gain_o_next;
        flip_o_reg  <= flip_o_next;
        total_o_reg <= total_o_next;
        val_o_reg   <= val_o_next;
        err_o_reg   <= err_o_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   state_next = clr_last ? ST_IDLE : ST_CLEAR;
            ST_IDLE:    state_next = req.valid ? ST_DEC : ST_IDLE;
            ST_DEC:
            begin
                case (cmd_reg)
                    CMD_LOAD:   state_next = load_ok ? ST_LD_RD : ST_FIN_RD;
                    CMD_MAJ:    state_next = ST_MJ_VAR;
                    CMD_RECNT:  state_next = ST_RC_CL;
                    CMD_FLIP:   state_next = v_ok ? ST_FL_RD : ST_FIN_RD;
                    CMD_TOGGLE: state_next = v_ok ? ST_TG_RD : ST_FIN_RD;
                    default:    state_next = ST_FIN_RD;
                endcase
            end
            ST_LD_RD:   state_next = ST_LD_WR;
            ST_LD_WR:   state_next = ST_FIN_RD;
            ST_MJ_VAR:
            begin
                if (vi_ok)
                begin
                    state_next = ST_MJ_CNT;
                end
                else if (vi_last)
                begin
                    state_next = ST_RC_CL;
                end
            end
            ST_MJ_CNT:  state_next = ST_MJ_OCC;
            ST_MJ_OCC:  state_next = (oi_reg >= ocnt_reg) ? ST_MJ_SET : ST_MJ_CL;
            ST_MJ_CL:   state_next = occ_ok ? ST_MJ_ADD : ST_MJ_OCC;
            ST_MJ_ADD:  state_next = ST_MJ_OCC;
            ST_MJ_SET:  state_next = vi_last ? ST_RC_CL : ST_MJ_VAR;
            ST_RC_CL:   state_next = ci_done ? ST_FIN_RD : ST_RC_LEN;
            ST_RC_LEN:  state_next = ST_RC_LIT;
            ST_RC_LIT:  state_next = (j_reg >= len_reg) ? ST_RC_WR : ST_RC_ASG;
            ST_RC_ASG:  state_next = ST_RC_CHK;
            ST_RC_CHK:  state_next = ST_RC_LIT;
            ST_RC_WR:   state_next = ST_RC_CL;
            ST_FL_RD:   state_next = ST_FL_CNT;
            ST_FL_CNT:  state_next = ST_FL_OCC;
            ST_FL_OCC:  state_next = (oi_reg >= ocnt_reg) ? ST_FL_END : ST_FL_CL;
            ST_FL_CL:   state_next = occ_ok ? ST_FL_HDR : ST_FL_OCC;
            ST_FL_HDR:  state_next = ST_FL_LIT;
            ST_FL_LIT:  state_next = (j_reg >= len_reg) ? ST_FL_EVAL : ST_FL_CMP;
            ST_FL_CMP:  state_next = (lit_var == VW'(var_reg)) ? ST_FL_EVAL : ST_FL_LIT;
            ST_FL_EVAL: state_next = ST_FL_OCC;
            ST_FL_END:  state_next = (!apply_reg && acc_pos) ? ST_FL_OCC : ST_FIN_RD;
            ST_TG_RD:   state_next = ST_TG_WR;
            ST_TG_WR:   state_next = ST_FIN_RD;
            ST_FIN_RD:  state_next = ST_FIN;
            ST_FIN:     state_next = ST_RESP;
            ST_RESP:    state_next = rsp.ready ? ST_IDLE : ST_RESP;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        clr_next     = clr_reg;
        cmd_next     = cmd_reg;
        cl_next      = cl_reg;
        var_next     = var_reg;
        neg_next     = neg_reg;
        w_next       = w_reg;
        vi_next      = vi_reg;
        ci_next      = ci_reg;
        oi_next      = oi_reg;
        ocnt_next    = ocnt_reg;
        j_next       = j_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        tc_next      = tc_reg;
        wc_next      = wc_reg;
        cc_next      = cc_reg;
        nc_next      = nc_reg;
        asgv_next    = asgv_reg;
        lt_next      = lt_reg;
        apply_next   = apply_reg;
        vok_next     = vok_reg;
        acc_next     = acc_reg;
        total_next   = total_reg;
        err_next     = err_reg;
        flip_next    = flip_reg;
        gain_o_next  = gain_o_reg;
        flip_o_next  = flip_o_reg;
        total_o_next = total_o_reg;
        val_o_next   = val_o_reg;
        err_o_next   = err_o_reg;

        lit_ra  = LA_W'(int'(cc_reg) * MAX_LITS + int'(j_reg));
        lit_wa  = LA_W'(int'(CW'(cl_reg)) * MAX_LITS + int'(rd_len));
        lit_wd  = {neg_reg, VW'(var_reg)};
        lit_we  = 1'b0;
        occ_ra  = OA_W'(int'(VW'(var_reg)) * MAX_OCC + int'(oi_reg));
        occ_wa  = OA_W'(int'(VW'(var_reg)) * MAX_OCC + int'(rd_ocnt));
        occ_wd  = {neg_reg, CW'(cl_reg)};
        occ_we  = 1'b0;
        wgt_ra  = occ_c;
        wgt_wa  = CW'(cl_reg);
        wgt_we  = 1'b0;
        len_ra  = occ_c;
        len_wa  = CW'(cl_reg);
        len_wd  = rd_len + LW'(1);
        len_we  = 1'b0;
        tc_ra   = occ_c;
        tc_wa   = cc_reg;
        tc_wd   = cnt_reg;
        tc_we   = 1'b0;
        ocnt_ra = VW'(var_reg);
        ocnt_wa = VW'(var_reg);
        ocnt_wd = rd_ocnt + OCW'(1);
        ocnt_we = 1'b0;
        asg_ra  = VW'(var_reg);
        asg_wa  = VW'(var_reg);
        asg_wd  = 1'b0;
        asg_we  = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + CLR_W'(1);
                len_wa   = CW'(clr_reg);
                len_wd   = '0;
                len_we   = (int'(clr_reg) < MAX_CLAUSES);
                tc_wa    = CW'(clr_reg);
                tc_wd    = '0;
                tc_we    = (int'(clr_reg) < MAX_CLAUSES);
                ocnt_wa  = VW'(clr_reg);
                ocnt_wd  = '0;
                ocnt_we  = (int'(clr_reg) <= MAX_VARS);
                asg_wa   = VW'(clr_reg);
                asg_wd   = 1'b0;
                asg_we   = (int'(clr_reg) <= MAX_VARS);
            end
            ST_IDLE:
            begin
                cmd_next = req.command;
                cl_next  = req.clause_index;
                var_next = req.var_index;
                neg_next = req.negated;
                w_next   = req.clause_weight;
            end
            ST_DEC:
            begin
                vok_next   = v_ok;
                acc_next   = '0;
                vi_next    = '0;
                ci_next    = '0;
                apply_next = 1'b0;
                flip_next  = 1'b0;
                err_next   = ERR_OK;
                case (cmd_reg)
                    CMD_LOAD:   err_next = load_ok ? ERR_OK : ERR_RANGE;
                    CMD_MAJ:    err_next = ERR_OK;
                    CMD_RECNT:  err_next = ERR_OK;
                    CMD_FLIP:   err_next = v_ok ? ERR_OK : ERR_RANGE;
                    CMD_TOGGLE: err_next = v_ok ? ERR_OK : ERR_RANGE;
                    CMD_READ:   err_next = v_ok ? ERR_OK : ERR_RANGE;
                    default:    err_next = ERR_RANGE;
                endcase
            end
            ST_LD_RD:
            begin
                len_ra = CW'(cl_reg);
            end
            ST_LD_WR:
            begin
                if (ld_full)
                begin
                    err_next = ERR_FULL;
                end
                else
                begin
                    lit_we  = 1'b1;
                    occ_we  = 1'b1;
                    wgt_we  = 1'b1;
                    len_we  = 1'b1;
                    ocnt_we = 1'b1;
                end
            end
            ST_MJ_VAR:
            begin
                ocnt_ra  = vi_reg;
                acc_next = '0;
                if (!vi_ok)
                begin
                    asg_wa  = vi_reg;
                    asg_wd  = 1'b0;
                    asg_we  = 1'b1;
                    vi_next = vi_reg + VW'(1);
                    ci_next = '0;
                end
            end
            ST_MJ_CNT:
            begin
                ocnt_next = rd_ocnt;
                oi_next   = '0;
            end
            ST_MJ_OCC:
            begin
                occ_ra = OA_W'(int'(vi_reg) * MAX_OCC + int'(oi_reg));
            end
            ST_MJ_CL:
            begin
                nc_next = occ_neg;
                if (!occ_ok)
                begin
                    oi_next = oi_reg + OCW'(1);
                end
            end
            ST_MJ_ADD:
            begin
                acc_next = nc_reg ? acc_reg - wgt_ext : acc_reg + wgt_ext;
                oi_next  = oi_reg + OCW'(1);
            end
            ST_MJ_SET:
            begin
                asg_wa   = vi_reg;
                asg_wd   = acc_pos;
                asg_we   = 1'b1;
                vi_next  = vi_reg + VW'(1);
                ci_next  = '0;
                acc_next = '0;
            end
            ST_RC_CL:
            begin
                len_ra = CW'(ci_reg);
                wgt_ra = CW'(ci_reg);
                if (ci_done)
                begin
                    total_next = acc_reg[TOTAL_W-1:0];
                end
            end
            ST_RC_LEN:
            begin
                len_next = rd_len;
                wc_next  = rd_wgt;
                cc_next  = CW'(ci_reg);
                j_next   = '0;
                cnt_next = '0;
            end
            ST_RC_ASG:
            begin
                asg_ra  = lit_var;
                nc_next = lit_neg;
            end
            ST_RC_CHK:
            begin
                if (nc_reg ? !rd_asg : rd_asg)
                begin
                    cnt_next = cnt_reg + TC_W'(1);
                end
                j_next = j_reg + LW'(1);
            end
            ST_RC_WR:
            begin
                tc_we = 1'b1;
                if (cnt_reg != '0)
                begin
                    acc_next = acc_reg + wc_ext;
                end
                ci_next = ci_reg + CW1'(1);
            end
            ST_FL_CNT:
            begin
                ocnt_next = rd_ocnt;
                asgv_next = rd_asg;
                oi_next   = '0;
            end
            ST_FL_CL:
            begin
                cc_next = occ_c;
                j_next  = '0;
                if (!occ_ok)
                begin
                    oi_next = oi_reg + OCW'(1);
                end
            end
            ST_FL_HDR:
            begin
                len_next = rd_len;
                tc_next  = rd_tc;
                wc_next  = rd_wgt;
            end
            ST_FL_LIT:
            begin
                lt_next = 1'b0;
            end
            ST_FL_CMP:
            begin
                lt_next = lit_true_now;
                j_next  = j_reg + LW'(1);
            end
            ST_FL_EVAL:
            begin
                oi_next = oi_reg + OCW'(1);
                if (apply_reg)
                begin
                    tc_wd = lt_reg ? tc_reg - TC_W'(1) : tc_reg + TC_W'(1);
                    tc_we = 1'b1;
                end
                else if (lt_reg && tc_reg == TC_W'(1))
                begin
                    acc_next = acc_reg - wc_ext;
                end
                else if (!lt_reg && tc_reg == '0)
                begin
                    acc_next = acc_reg + wc_ext;
                end
            end
            ST_FL_END:
            begin
                oi_next = '0;
                if (apply_reg)
                begin
                    asg_wd     = !asgv_reg;
                    asg_we     = 1'b1;
                    total_next = total_reg + acc_reg[TOTAL_W-1:0];
                    flip_next  = 1'b1;
                end
                else if (acc_pos)
                begin
                    apply_next = 1'b1;
                end
            end
            ST_TG_WR:
            begin
                asg_wd = !rd_asg;
                asg_we = 1'b1;
            end
            ST_FIN:
            begin
                gain_o_next  = (cmd_reg == CMD_FLIP) ? acc_reg : '0;
                flip_o_next  = flip_reg;
                total_o_next = total_reg;
                val_o_next   = vok_reg && rd_asg;
                err_o_next   = err_reg;
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

endmodule
